>>> hdl/spr_pkg.sv
package spr_pkg;

    localparam int NUM_VERTICES = 32;
    localparam int VTX_W        = 5;
    localparam int MASK_W       = 32;

    typedef logic [NUM_VERTICES-1:0] t_vset;
    typedef logic [VTX_W-1:0]        t_vtx;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0] opcode;
        t_vtx       from_vertex;
        t_vtx       to_vertex;
    } t_in;

    typedef struct packed {
        logic edge_was_new;
        logic path_found;
    } t_out;

    // adjacency store command
    typedef struct packed {
        logic ins;
        logic clr;
        t_vtx row;
        t_vtx col;
    } t_adj_cmd;

    // expansion unit control and status
    typedef struct packed {
        logic init;
        logic step;
        t_vtx src;
    } t_exp_ctl;

    typedef struct packed {
        logic  done;
        t_vtx  pick;
        t_vset visited;
    } t_exp_stat;

    function automatic t_vset vset_from_mask(input logic [MASK_W-1:0] m);
        t_vset s;
        for (int i = 0; i < NUM_VERTICES; i++) begin
            s[i] = (i < MASK_W) ? m[i % MASK_W] : 1'b0;
        end
        return s;
    endfunction

    function automatic logic vtx_in_range(input t_vtx v);
        return ({1'b0, v} < (VTX_W+1)'(NUM_VERTICES));
    endfunction

endpackage

>>> hdl/safe_path_reachability.sv
// channel   | valid       | flow control | payload
// ----------+-------------+--------------+------------------------
// input     | i_in_valid  | o_in_stall   | i_in_data  (t_in)
// result    | o_out_valid | i_out_stall  | o_out_data (t_out)
// config    | i_cfg_valid | o_cfg_ready  | i_cfg_data (safe_mask)
//
// insert, clear and unused opcodes go from accept through S_EXEC and S_RESULT to the output register
// a search adds S_SEARCH after S_EXEC, visiting the k <= NUM_VERTICES vertices it
// reaches, since the shared expansion unit handles one reached vertex per cycle
// i_rst_n (synchronous) clears the graph, the output valid flag, the fsm,
// and sets safe_mask to all ones
// o_in_stall is high from accept until the result is moved to the output
// register; a stalled result waits there while the next transaction is taken
module safe_path_reachability
    import spr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MASK_W-1:0] i_cfg_data
);

    t_state            r_state, n_state;
    t_in               r_item;
    t_out              r_result, n_result;
    logic              r_out_valid;
    t_out              r_out_data;
    logic [MASK_W-1:0] r_safe_mask;

    t_adj_cmd  adj_cmd;
    t_vtx      rd_row;
    t_vset     rd_data;
    t_exp_ctl  exp_ctl;
    t_exp_stat exp_stat;
    logic      in_take;
    logic      out_free;
    logic      both_in_range;

    assign in_take       = i_in_valid && (r_state == S_IDLE);
    assign out_free      = !r_out_valid || !i_out_stall;
    assign both_in_range = vtx_in_range(r_item.from_vertex) && vtx_in_range(r_item.to_vertex);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // safe mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe_mask <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_safe_mask <= i_cfg_data;
        end
    end

    // graph rows
    spr_adj_store u_adj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (adj_cmd),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data)
    );

    // shared expansion unit: one frontier vertex per cycle while searching
    spr_expand u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (exp_ctl),
        .i_row   (rd_data),
        .i_safe  (vset_from_mask(r_safe_mask)),
        .o_stat  (exp_stat)
    );

    // row read: operand row while executing, frontier pick while searching
    assign rd_row = (r_state == S_SEARCH) ? exp_stat.pick : r_item.from_vertex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_data;
        end
        r_result <= n_result;
    end

    always_comb begin
        n_state      = r_state;
        n_result     = r_result;
        adj_cmd      = '0;
        adj_cmd.row  = r_item.from_vertex;
        adj_cmd.col  = r_item.to_vertex;
        exp_ctl      = '0;
        exp_ctl.src  = r_item.from_vertex;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_result = '0;
                n_state  = S_RESULT;
                case (r_item.opcode)
                    OP_INSERT: begin
                        if (both_in_range) begin
                            // new when the bit was clear before the write
                            n_result.edge_was_new = !rd_data[r_item.to_vertex];
                            adj_cmd.ins           = 1'b1;
                        end
                    end
                    OP_SEARCH: begin
                        if (both_in_range) begin
                            exp_ctl.init = 1'b1;
                            n_state      = S_SEARCH;
                        end
                    end
                    OP_CLEAR: begin
                        adj_cmd.clr = 1'b1;
                    end
                    default: begin
                        // unused opcode: no effect, zero result
                    end
                endcase
            end
            S_SEARCH: begin
                if (exp_stat.done) begin
                    n_result.path_found = exp_stat.visited[r_item.to_vertex];
                    n_state             = S_RESULT;
                end else begin
                    exp_ctl.step = 1'b1;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register, loaded only once the previous transaction has left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RESULT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && out_free) begin
            r_out_data <= r_result;
        end
    end

    // a finished frontier always ends the search
    a_search_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && exp_stat.done) |=> (r_state == S_RESULT))
        else $error("search did not end on empty frontier");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_out_valid && i_out_stall) |=> (r_state == S_RESULT))
        else $error("result register overwritten while stalled");

    // the search answer matches the visited set it was taken from
    a_found_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && $past(r_state) == S_SEARCH)
            |-> (r_result.path_found == exp_stat.visited[r_item.to_vertex]))
        else $error("path_found disagrees with visited set");

    // an accepted transaction always goes to execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

endmodule

>>> hdl/spr_adj_store.sv
module spr_adj_store
    import spr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_adj_cmd i_cmd,
    input  t_vtx     i_rd_row,
    output t_vset    o_rd_data
);

    t_vset r_rows [NUM_VERTICES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            for (int i = 0; i < NUM_VERTICES; i++) begin
                r_rows[i] <= '0;
            end
        end else if (i_cmd.ins) begin
            r_rows[i_cmd.row][i_cmd.col] <= 1'b1;
        end
    end

    assign o_rd_data = r_rows[i_rd_row];

endmodule

>>> hdl/spr_expand.sv
module spr_expand
    import spr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_exp_ctl  i_ctl,
    input  t_vset     i_row,
    input  t_vset     i_safe,
    output t_exp_stat o_stat
);

    t_vset r_visit, n_visit;
    t_vset r_front, n_front;
    t_vtx  pick;
    t_vset fresh;
    t_vset src_bit;
    t_vset pick_bit;

    // lowest pending vertex of the frontier
    always_comb begin
        pick = '0;
        for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
            if (r_front[i]) begin
                pick = VTX_W'(i);
            end
        end
    end

    always_comb begin
        src_bit  = t_vset'(1) << i_ctl.src;
        pick_bit = t_vset'(1) << pick;
        fresh    = i_row & i_safe & ~r_visit;
        n_visit  = r_visit;
        n_front  = r_front;
        if (i_ctl.init) begin
            n_visit = src_bit;
            n_front = src_bit;
        end else if (i_ctl.step) begin
            n_visit = r_visit | fresh;
            n_front = (r_front & ~pick_bit) | fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visit <= '0;
            r_front <= '0;
        end else begin
            r_visit <= n_visit;
            r_front <= n_front;
        end
    end

    assign o_stat.done    = (r_front == '0);
    assign o_stat.pick    = pick;
    assign o_stat.visited = r_visit;

endmodule
